FILE: sv/grb_pkg.sv
`default_nettype none

package grb_pkg;

    localparam int NUM_CLASSES = 64;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W       = 6;
    localparam int GAIN_W      = 16;
    localparam int REQ_W       = 17;
    localparam int RAMP_W      = 16;
    localparam int TICK_W      = 15;
    localparam int TT_W        = GAIN_W + TICK_W;
    localparam int PROD_W      = 30;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = 4;

    localparam logic [GAIN_W-1:0] FULL_SCALE = 16'd32768;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_ADV    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_REINIT = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SET,
        S_ADV_RD,
        S_ADV_EVAL,
        S_ADV_MUL,
        S_ADV_DINIT,
        S_ADV_DIV,
        S_ADV_WR,
        S_RD_RD,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_all;
        logic set_wr;
        logic adv_rd;
        logic adv_eval;
        logic mul;
        logic div_init;
        logic div_step;
        logic adv_wr;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  n_zero;
        logic  cls_last;
        logic  ramping;
        logic  div_last;
        logic  out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/gain_ramp_bank_unit.sv
`default_nettype none

// Bank of 64 per-class gain faders, unsigned Q1.15 (32768 = 1.0). One input
// transaction at a time: kind 0 sets target (clamped to 0..32768) and ramp
// length (negative = 0) for every class in class_mask; kind 1 advances all
// classes by tick_count ticks (a class with more ticks left than N moves by
// N*(target-current)/ticks_left, truncated toward zero, otherwise it lands on
// its target); kind 2 returns one output transaction with the class's current
// gain; kind 3 restores full scale and clears all ramps. Only reads produce
// output transactions. A set writes one RAM entry per class; reinit and a
// zero-tick advance return to ready from decode; a read waits while the
// output register stays full; an advance takes each class through read,
// evaluate, multiply, a divide if the class is ramping, and write-back. The
// advance cost is set by a single shared restoring divider that retires one
// quotient bit per cycle (16 bits per ramping class) behind a read, a
// multiply and a write-back of the level RAMs. State lives in two
// single-port-write RAMs (current level; target and ticks left) with
// flop valid bits, so reset and reinit take effect at once without a clear
// pass. The output register lets a read result wait while the next
// transaction is accepted.
module gain_ramp_bank_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_kind,
    input  wire logic [63:0]                        i_class_mask,
    input  wire logic signed [grb_pkg::REQ_W-1:0]   i_gain_request,
    input  wire logic signed [grb_pkg::RAMP_W-1:0]  i_ramp_ticks,
    input  wire logic [grb_pkg::TICK_W-1:0]         i_tick_count,
    input  wire logic [grb_pkg::IDX_W-1:0]          i_class_index,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [grb_pkg::GAIN_W-1:0]              o_gain_out,
    output logic [grb_pkg::IDX_W-1:0]               o_class_out
);

    import grb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: decodes the transaction and steps the per-class sweep
    grb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // level RAMs, multiplier, divider and output register
    grb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (i_kind),
        .i_class_mask   (i_class_mask),
        .i_gain_request (i_gain_request),
        .i_ramp_ticks   (i_ramp_ticks),
        .i_tick_count   (i_tick_count),
        .i_class_index  (i_class_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_gain_out     (o_gain_out),
        .o_class_out    (o_class_out)
    );

endmodule

`default_nettype wire

FILE: sv/grb_ram.sv
`default_nettype none

module grb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/grb_ctrl.sv
`default_nettype none

module grb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire grb_pkg::t_status  i_status,
    output grb_pkg::t_cmd          o_cmd
);

    import grb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_status.kind)
                    KIND_SET:    n_state = S_SET;
                    KIND_ADV:    n_state = i_status.n_zero ? S_IDLE : S_ADV_RD;
                    KIND_READ:   n_state = S_RD_RD;
                    KIND_REINIT: n_state = S_IDLE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_SET: begin
                if (i_status.cls_last) n_state = S_IDLE;
            end
            S_ADV_RD:    n_state = S_ADV_EVAL;
            S_ADV_EVAL:  n_state = S_ADV_MUL;
            S_ADV_MUL: begin
                n_state = i_status.ramping ? S_ADV_DINIT : S_ADV_WR;
            end
            S_ADV_DINIT: n_state = S_ADV_DIV;
            S_ADV_DIV: begin
                if (i_status.div_last) n_state = S_ADV_WR;
            end
            S_ADV_WR: begin
                n_state = i_status.cls_last ? S_IDLE : S_ADV_RD;
            end
            S_RD_RD:     n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.clear_all = (i_status.kind == KIND_REINIT);
            end
            S_SET:       o_cmd.set_wr   = 1'b1;
            S_ADV_RD:    o_cmd.adv_rd   = 1'b1;
            S_ADV_EVAL:  o_cmd.adv_eval = 1'b1;
            S_ADV_MUL:   o_cmd.mul      = 1'b1;
            S_ADV_DINIT: o_cmd.div_init = 1'b1;
            S_ADV_DIV:   o_cmd.div_step = 1'b1;
            S_ADV_WR:    o_cmd.adv_wr   = 1'b1;
            S_RD_RD:     o_cmd.rd_issue = 1'b1;
            S_RD_OUT:    o_cmd.out_load = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_DIV && !i_status.div_last) |=> (r_state == S_ADV_DIV))
        else $error("divider left early");

    a_set_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SET && i_status.cls_last) |=> o_in_ready)
        else $error("set sweep did not return to idle");

endmodule

`default_nettype wire

FILE: sv/grb_dp.sv
`default_nettype none

module grb_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire grb_pkg::t_cmd                          i_cmd,
    output grb_pkg::t_status                            o_status,
    input  wire logic [1:0]                             i_kind,
    input  wire logic [63:0]                            i_class_mask,
    input  wire logic signed [grb_pkg::REQ_W-1:0]       i_gain_request,
    input  wire logic signed [grb_pkg::RAMP_W-1:0]      i_ramp_ticks,
    input  wire logic [grb_pkg::TICK_W-1:0]             i_tick_count,
    input  wire logic [grb_pkg::IDX_W-1:0]              i_class_index,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [grb_pkg::GAIN_W-1:0]                  o_gain_out,
    output logic [grb_pkg::IDX_W-1:0]                   o_class_out
);

    import grb_pkg::*;

    // captured transaction
    t_kind                  r_kind;
    logic [NUM_CLASSES-1:0] r_mask;
    logic [GAIN_W-1:0]      r_gain;
    logic [TICK_W-1:0]      r_ramp;
    logic [TICK_W-1:0]      r_n;
    logic [IDX_W-1:0]       r_idx;

    // sweep and per-entry valid bits (invalid reads as reset value)
    logic [CLS_W-1:0]       r_cls;
    logic [NUM_CLASSES-1:0] r_cur_vld;
    logic [NUM_CLASSES-1:0] r_tt_vld;

    // per-class operands
    logic [GAIN_W-1:0]      r_cur;
    logic [GAIN_W-1:0]      r_tgt;
    logic [TICK_W-1:0]      r_ticks;
    logic                   r_neg;
    logic [GAIN_W-1:0]      r_mag;
    logic [PROD_W-1:0]      r_prod;
    logic [TICK_W-1:0]      r_rem;
    logic [GAIN_W-1:0]      r_quo;
    logic [DIV_CNT_W-1:0]   r_div_cnt;

    logic                   r_out_valid;
    logic [GAIN_W-1:0]      r_out_gain;
    logic [IDX_W-1:0]       r_out_class;

    logic [GAIN_W-1:0]      n_gain;
    logic [TICK_W-1:0]      n_ramp;
    logic [GAIN_W-1:0]      cur_q;
    logic [TT_W-1:0]        tt_q;
    logic [GAIN_W-1:0]      n_cur_eff;
    logic [TT_W-1:0]        n_tt_eff;
    logic [GAIN_W:0]        n_diff;
    logic [GAIN_W:0]        n_diff_abs;
    logic [PROD_W:0]        n_prod;
    logic [GAIN_W-1:0]      n_trial;
    logic                   n_ge;
    logic                   n_ramping;
    logic [GAIN_W-1:0]      n_cur_wr;
    logic [TICK_W-1:0]      n_ticks_wr;
    logic                   n_in_range;
    logic [GAIN_W-1:0]      n_rd_gain;
    logic                   tt_we;
    logic [TT_W-1:0]        tt_wdata;
    logic                   cur_re;
    logic [CLS_W-1:0]       cur_raddr;

    // clamp request fields
    always_comb begin
        if (i_gain_request < 0) begin
            n_gain = '0;
        end else if (i_gain_request > $signed({1'b0, FULL_SCALE})) begin
            n_gain = FULL_SCALE;
        end else begin
            n_gain = i_gain_request[GAIN_W-1:0];
        end
        n_ramp = i_ramp_ticks[RAMP_W-1] ? '0 : i_ramp_ticks[TICK_W-1:0];
    end

    always_comb begin
        n_cur_eff  = r_cur_vld[r_cls] ? cur_q : FULL_SCALE;
        n_tt_eff   = r_tt_vld[r_cls] ? tt_q : {FULL_SCALE, {TICK_W{1'b0}}};
        n_diff     = {1'b0, n_tt_eff[TT_W-1:TICK_W]} - {1'b0, n_cur_eff};
        n_diff_abs = n_diff[GAIN_W] ? (GAIN_W+1)'(-n_diff) : n_diff;
        n_prod     = {{(PROD_W+1-TICK_W){1'b0}}, r_n} * {{(PROD_W+1-GAIN_W){1'b0}}, r_mag};
        n_trial    = {r_rem, r_quo[GAIN_W-1]};
        n_ge       = (n_trial >= {1'b0, r_ticks});
        n_ramping  = (r_ticks > r_n);
        if (n_ramping) begin
            n_cur_wr   = r_neg ? GAIN_W'(r_cur - r_quo) : GAIN_W'(r_cur + r_quo);
            n_ticks_wr = TICK_W'(r_ticks - r_n);
        end else begin
            n_cur_wr   = r_tgt;
            n_ticks_wr = '0;
        end
        n_in_range = ({1'b0, r_idx} < (IDX_W+1)'(NUM_CLASSES));
        if (!n_in_range) begin
            n_rd_gain = '0;
        end else begin
            n_rd_gain = r_cur_vld[r_idx[CLS_W-1:0]] ? cur_q : FULL_SCALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_mask <= i_class_mask[NUM_CLASSES-1:0];
            r_gain <= n_gain;
            r_ramp <= n_ramp;
            r_n    <= i_tick_count;
            r_idx  <= i_class_index;
        end
        if (i_cmd.adv_eval) begin
            r_cur   <= n_cur_eff;
            r_tgt   <= n_tt_eff[TT_W-1:TICK_W];
            r_ticks <= n_tt_eff[TICK_W-1:0];
            r_neg   <= n_diff[GAIN_W];
            r_mag   <= n_diff_abs[GAIN_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod[PROD_W-1:0];
        end
        // quotient is below 2^15, so the top of the product starts below the divisor
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_prod[PROD_W-1:GAIN_W]};
            r_quo <= r_prod[GAIN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= n_ge ? TICK_W'(n_trial - {1'b0, r_ticks}) : n_trial[TICK_W-1:0];
            r_quo <= {r_quo[GAIN_W-2:0], n_ge};
        end
        if (i_cmd.out_load) begin
            r_out_gain  <= n_rd_gain;
            r_out_class <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls       <= '0;
            r_cur_vld   <= '0;
            r_tt_vld    <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cls <= '0;
            end else if (i_cmd.set_wr || i_cmd.adv_wr) begin
                r_cls <= CLS_W'(r_cls + 1'b1);
            end
            if (i_cmd.clear_all) begin
                r_cur_vld <= '0;
                r_tt_vld  <= '0;
            end else begin
                if (i_cmd.set_wr && r_mask[r_cls]) r_tt_vld[r_cls] <= 1'b1;
                if (i_cmd.adv_wr) begin
                    r_cur_vld[r_cls] <= 1'b1;
                    r_tt_vld[r_cls]  <= 1'b1;
                end
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= DIV_CNT_W'(r_div_cnt + 1'b1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign tt_we     = (i_cmd.set_wr && r_mask[r_cls]) || i_cmd.adv_wr;
    assign tt_wdata  = i_cmd.set_wr ? {r_gain, r_ramp} : {r_tgt, n_ticks_wr};
    assign cur_re    = i_cmd.adv_rd || i_cmd.rd_issue;
    assign cur_raddr = i_cmd.rd_issue ? r_idx[CLS_W-1:0] : r_cls;

    grb_ram #(
        .WIDTH (GAIN_W),
        .DEPTH (NUM_CLASSES)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.adv_wr),
        .i_waddr (r_cls),
        .i_wdata (n_cur_wr),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_q)
    );

    grb_ram #(
        .WIDTH (TT_W),
        .DEPTH (NUM_CLASSES)
    ) u_tt_ram (
        .i_clk   (i_clk),
        .i_we    (tt_we),
        .i_waddr (r_cls),
        .i_wdata (tt_wdata),
        .i_re    (i_cmd.adv_rd),
        .i_raddr (r_cls),
        .o_rdata (tt_q)
    );

    always_comb begin
        o_status.kind     = r_kind;
        o_status.n_zero   = (r_n == '0);
        o_status.cls_last = (r_cls == CLS_W'(NUM_CLASSES - 1));
        o_status.ramping  = n_ramping;
        o_status.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_gain_out  = r_out_gain;
    assign o_class_out = r_out_class;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv_wr |-> (n_cur_wr <= FULL_SCALE))
        else $error("written gain above full scale");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> ({1'b0, r_prod[PROD_W-1:GAIN_W]} < r_ticks))
        else $error("divider start remainder not below divisor");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.adv_wr && n_ramping) |-> (r_quo <= r_mag))
        else $error("ramp step larger than distance to target");

endmodule

`default_nettype wire
